FILE: rtl/bnkrf_pkg.sv
// Shared types, constants and mode tables for the banked register file.
package bnkrf_pkg;

    typedef enum logic [1:0] {
        REQ_READ   = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_STATUS = 2'd2,
        REQ_EXCEPT = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        BANK_USR = 3'd0,
        BANK_FIQ = 3'd1,
        BANK_IRQ = 3'd2,
        BANK_SVC = 3'd3,
        BANK_ABT = 3'd4,
        BANK_UND = 3'd5
    } t_bank;

    typedef enum logic [0:0] {
        CFG_EXC_BASE = 1'b0,
        CFG_RESET_PC = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] new_status;
        t_bank       new_bank;
        logic        unknown;
        logic        save_en;
        logic        written;
    } t_mode_upd;

    localparam logic [31:0] STATUS_RESET = 32'h0000_00D3;
    localparam logic [31:0] RESET_PC     = 32'h0001_0000;

    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    function automatic logic [4:0] entry_mode(input logic [2:0] sel);
        logic [4:0] m;
        case (sel)
            3'd0:    m = MODE_SVC;
            3'd1:    m = MODE_UND;
            3'd2:    m = MODE_SVC;
            3'd3:    m = MODE_ABT;
            3'd4:    m = MODE_ABT;
            3'd5:    m = MODE_SVC;
            3'd6:    m = MODE_IRQ;
            default: m = MODE_FIQ;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/bnkrf_mode_ctl.sv
// Status word update and bank selection for status writes and exceptions.
module bnkrf_mode_ctl (
    input  bnkrf_pkg::t_req      i_req,
    input  logic [31:0]          i_data,
    input  logic                 i_save,
    input  logic [4:0]           i_vector,
    input  logic [31:0]          i_status,
    input  bnkrf_pkg::t_bank     i_bank,
    output bnkrf_pkg::t_mode_upd o_upd
);

    logic [31:0] value;
    logic        save;
    logic        active;
    logic [4:0]  mode;

    always_comb begin
        value  = i_status;
        save   = 1'b0;
        active = 1'b0;
        mode   = bnkrf_pkg::entry_mode(i_vector[4:2]);
        case (i_req)
            bnkrf_pkg::REQ_STATUS: begin
                value  = i_data;
                save   = i_save;
                active = 1'b1;
            end
            bnkrf_pkg::REQ_EXCEPT: begin
                value  = {i_status[31:8], 1'b1, i_status[6], 1'b0, mode};
                save   = 1'b1;
                active = 1'b1;
            end
            default: begin
                value  = i_status;
                save   = 1'b0;
                active = 1'b0;
            end
        endcase

        o_upd.new_status = active ? value : i_status;
        o_upd.new_bank   = i_bank;
        o_upd.unknown    = 1'b0;
        o_upd.written    = active;
        if (active && (value[4:0] != i_status[4:0])) begin
            case (value[4:0])
                bnkrf_pkg::MODE_USR: o_upd.new_bank = bnkrf_pkg::BANK_USR;
                bnkrf_pkg::MODE_SYS: o_upd.new_bank = bnkrf_pkg::BANK_USR;
                bnkrf_pkg::MODE_FIQ: o_upd.new_bank = bnkrf_pkg::BANK_FIQ;
                bnkrf_pkg::MODE_IRQ: o_upd.new_bank = bnkrf_pkg::BANK_IRQ;
                bnkrf_pkg::MODE_SVC: o_upd.new_bank = bnkrf_pkg::BANK_SVC;
                bnkrf_pkg::MODE_ABT: o_upd.new_bank = bnkrf_pkg::BANK_ABT;
                bnkrf_pkg::MODE_UND: o_upd.new_bank = bnkrf_pkg::BANK_UND;
                default:             o_upd.unknown  = 1'b1;
            endcase
        end
        o_upd.save_en = active && save && (o_upd.new_bank != bnkrf_pkg::BANK_USR);
    end

endmodule

FILE: rtl/banked_register_file_mode_switch_core.sv
// Top level of the mode-banked general register file.
// Each accepted request is registered at the input; its result is registered at the output.
// One request per cycle unless stalled; each reads and updates the banks in one pass.
// Reset is synchronous: all banks clear, r15 loads 0x10000, status is 0xD3, supervisor bank.
// The configuration port is always ready; users must write it only while the core is idle.
module banked_register_file_mode_switch_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [3:0]  i_reg_index,
    input  logic [31:0] i_write_data,
    input  logic        i_save_old,
    input  logic [4:0]  i_vector,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic [31:0] o_status_out,
    output logic [31:0] o_saved_status_out,
    output logic        o_saved_status_valid,
    output logic        o_mode_unknown,
    output logic        o_status_written,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic                 r_in_valid;
    bnkrf_pkg::t_req      r_req;
    logic [3:0]           r_idx;
    logic [31:0]          r_data;
    logic                 r_save;
    logic [4:0]           r_vec;

    logic [31:0]          r_user [16];
    logic [31:0]          r_fiq [7];
    logic [31:0]          r_small [8];
    logic [31:0]          r_spsr [5];
    logic [31:0]          r_status;
    bnkrf_pkg::t_bank     r_bank;
    logic [31:0]          r_exc_base;

    logic                 r_out_valid;
    logic [31:0]          r_read_data;
    logic [31:0]          r_status_out;
    logic [31:0]          r_spsr_out;
    logic                 r_spsr_valid;
    logic                 r_unknown;
    logic                 r_written;

    bnkrf_pkg::t_mode_upd upd;
    logic                 in_acc;
    logic                 advance;
    logic                 fiq_hit;
    logic                 small_hit;
    logic [2:0]           fiq_idx;
    logic [2:0]           bank_off;
    logic [2:0]           small_idx;
    logic [2:0]           new_bank_off;
    logic [2:0]           new_small_lr;
    logic [2:0]           spsr_idx;
    logic                 new_has_spsr;
    logic [31:0]          n_read_data;
    logic [31:0]          n_spsr_out;
    logic [31:0]          lr_val;
    logic [31:0]          pc_new;
    logic [31:0]          vec_sum;

    bnkrf_mode_ctl u_mode_ctl (
        .i_req    (r_req),
        .i_data   (r_data),
        .i_save   (r_save),
        .i_vector (r_vec),
        .i_status (r_status),
        .i_bank   (r_bank),
        .o_upd    (upd)
    );

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        fiq_hit   = (r_idx >= 4'd8) && (r_idx <= 4'd14) && (r_bank == bnkrf_pkg::BANK_FIQ);
        small_hit = ((r_idx == 4'd13) || (r_idx == 4'd14))
                    && (r_bank >= bnkrf_pkg::BANK_IRQ) && (r_bank <= bnkrf_pkg::BANK_UND);
        fiq_idx   = r_idx[2:0];
        bank_off  = 3'(r_bank) - 3'd2;
        small_idx = {bank_off[1:0], (r_idx == 4'd14)};

        new_has_spsr = (upd.new_bank != bnkrf_pkg::BANK_USR);
        spsr_idx     = 3'(upd.new_bank) - 3'd1;
        new_bank_off = 3'(upd.new_bank) - 3'd2;
        new_small_lr = {new_bank_off[1:0], 1'b1};

        if (r_req != bnkrf_pkg::REQ_READ) begin
            n_read_data = 32'd0;
        end else if (fiq_hit) begin
            n_read_data = r_fiq[fiq_idx];
        end else if (small_hit) begin
            n_read_data = r_small[small_idx];
        end else begin
            n_read_data = r_user[r_idx];
        end

        if (!new_has_spsr) begin
            n_spsr_out = 32'd0;
        end else if (upd.save_en) begin
            n_spsr_out = r_status;
        end else begin
            n_spsr_out = r_spsr[spsr_idx];
        end

        lr_val  = r_user[15] + {30'd0, new_has_spsr && r_status[5], 1'b0};
        vec_sum = r_exc_base + {27'd0, r_vec};
        pc_new  = {vec_sum[31:2], 2'b00} + 32'd4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= bnkrf_pkg::t_req'(i_req_type);
            r_idx  <= i_reg_index;
            r_data <= i_write_data;
            r_save <= i_save_old;
            r_vec  <= i_vector;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 15; i++) begin
                r_user[i] <= 32'd0;
            end
            r_user[15] <= bnkrf_pkg::RESET_PC;
            for (int i = 0; i < 7; i++) begin
                r_fiq[i] <= 32'd0;
            end
            for (int i = 0; i < 8; i++) begin
                r_small[i] <= 32'd0;
            end
            for (int i = 0; i < 5; i++) begin
                r_spsr[i] <= 32'd0;
            end
            r_status   <= bnkrf_pkg::STATUS_RESET;
            r_bank     <= bnkrf_pkg::BANK_SVC;
            r_exc_base <= 32'd0;
        end else begin
            if (i_cfg_valid) begin
                case (bnkrf_pkg::t_cfg_idx'(i_cfg_index))
                    bnkrf_pkg::CFG_EXC_BASE: r_exc_base <= i_cfg_data;
                    bnkrf_pkg::CFG_RESET_PC: r_user[15] <= i_cfg_data;
                    default:                 r_exc_base <= r_exc_base;
                endcase
            end
            if (advance) begin
                r_status <= upd.new_status;
                r_bank   <= upd.new_bank;
                if (upd.save_en) begin
                    r_spsr[spsr_idx] <= r_status;
                end
                case (r_req)
                    bnkrf_pkg::REQ_WRITE: begin
                        if (fiq_hit) begin
                            r_fiq[fiq_idx] <= r_data;
                        end else if (small_hit) begin
                            r_small[small_idx] <= r_data;
                        end else begin
                            r_user[r_idx] <= r_data;
                        end
                    end
                    bnkrf_pkg::REQ_EXCEPT: begin
                        if (upd.new_bank == bnkrf_pkg::BANK_FIQ) begin
                            r_fiq[6] <= lr_val;
                        end else if (new_has_spsr) begin
                            r_small[new_small_lr] <= lr_val;
                        end else begin
                            r_user[14] <= lr_val;
                        end
                        r_user[15] <= pc_new;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_read_data  <= n_read_data;
            r_status_out <= upd.new_status;
            r_spsr_out   <= n_spsr_out;
            r_spsr_valid <= new_has_spsr;
            r_unknown    <= upd.unknown;
            r_written    <= upd.written;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_read_data          = r_read_data;
    assign o_status_out         = r_status_out;
    assign o_saved_status_out   = r_spsr_out;
    assign o_saved_status_valid = r_spsr_valid;
    assign o_mode_unknown       = r_unknown;
    assign o_status_written     = r_written;

endmodule

FILE: rtl/bnkrf_checker.sv
// Port-level assertions for the banked register file, bound to the top level.
module bnkrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_read_data,
    input logic [31:0] o_status_out,
    input logic [31:0] o_saved_status_out,
    input logic        o_saved_status_valid,
    input logic        o_mode_unknown,
    input logic        o_status_written
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_status_out) && $stable(o_read_data))
        else $error("stalled result changed");

    a_unknown_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode_unknown |-> o_status_written)
        else $error("unknown mode flagged without a status change");

    a_no_spsr_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_saved_status_valid |-> (o_saved_status_out == 32'd0))
        else $error("saved status nonzero in a mode without one");

endmodule

bind banked_register_file_mode_switch_core bnkrf_checker u_bnkrf_checker (.*);
